@@ hw/rtl/smap_pkg.sv @@
// ----------------------------------------------------------------------------
// smap_pkg: shared types and constants for the serial bank mapper
// Action codes, register indexes, size limits, the bank register bundle and a size clamp.
// ----------------------------------------------------------------------------
package smap_pkg;

  localparam logic [1:0] ACT_WRITE   = 2'd0;
  localparam logic [1:0] ACT_PRG_ROM = 2'd1;
  localparam logic [1:0] ACT_CHR     = 2'd2;
  localparam logic [1:0] ACT_PRG_RAM = 2'd3;

  localparam logic [1:0] CFG_PRG_BANKS = 2'd0;
  localparam logic [1:0] CFG_CHR_UNITS = 2'd1;
  localparam logic [1:0] CFG_FIXED_32K = 2'd2;
  localparam logic [1:0] CFG_RAM_CTRL  = 2'd3;

  localparam int unsigned SIZE_W   = 6;   // width of the size registers
  localparam int unsigned QUOT_W   = 5;   // bank-number bits of an offset
  localparam int unsigned OFFS_W   = 19;
  localparam int unsigned MAX_UNITS = 32;

  localparam logic [4:0] SHIFT_EMPTY  = 5'h10;
  localparam logic [4:0] CONTROL_INIT = 5'h0C;

  typedef struct packed {
    logic [4:0] control;
    logic [4:0] chr_lo;
    logic [4:0] chr_hi;
    logic [4:0] prg;
  } smap_banks_t;

  // size of zero counts as one unit, anything above the maximum saturates
  function automatic logic [SIZE_W-1:0] clamp_units(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (v > SIZE_W'(MAX_UNITS)) begin
      r = SIZE_W'(MAX_UNITS);
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/smap_regs.sv @@
// ----------------------------------------------------------------------------
// smap_regs: serial load port and bank registers
// Five writes of data bit 0 fill one of the four internal registers.
// ----------------------------------------------------------------------------
module smap_regs (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [15:0]          wr_addr,
  input  logic [7:0]           wr_data,
  output smap_pkg::smap_banks_t banks
);

  logic [4:0]            shift_r, shift_nxt;
  smap_pkg::smap_banks_t banks_r, banks_nxt;
  logic [4:0]            loaded;

  assign loaded = {wr_data[0], shift_r[4:1]};

  always_comb begin
    shift_nxt = shift_r;
    banks_nxt = banks_r;
    if (wr_en) begin
      if (wr_data[7]) begin
        shift_nxt         = smap_pkg::SHIFT_EMPTY;
        banks_nxt.control = banks_r.control | smap_pkg::CONTROL_INIT;
      end else if (shift_r[0]) begin
        // marker reached bit 0: fifth bit, commit
        shift_nxt = smap_pkg::SHIFT_EMPTY;
        if (!wr_addr[15]) begin
          banks_nxt.control = loaded;
        end else begin
          case (wr_addr[14:13])
            2'd0:    banks_nxt.control = loaded;
            2'd1:    banks_nxt.chr_lo  = loaded;
            2'd2:    banks_nxt.chr_hi  = loaded;
            default: banks_nxt.prg     = loaded;
          endcase
        end
      end else begin
        shift_nxt = loaded;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r         <= smap_pkg::SHIFT_EMPTY;
      banks_r.control <= smap_pkg::CONTROL_INIT;
      banks_r.chr_lo  <= '0;
      banks_r.chr_hi  <= '0;
      banks_r.prg     <= '0;
    end else begin
      shift_r <= shift_nxt;
      banks_r <= banks_nxt;
    end
  end

  assign banks = banks_r;

endmodule

@@ hw/rtl/smap_rem.sv @@
// ----------------------------------------------------------------------------
// smap_rem: iterative remainder unit
// Restoring remainder of the bank number by the memory size, one bit a cycle.
// ----------------------------------------------------------------------------
module smap_rem (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [smap_pkg::QUOT_W-1:0]         num,
  input  logic [smap_pkg::SIZE_W-1:0]         div,
  output logic                                done,
  output logic [smap_pkg::QUOT_W-1:0]         rem
);

  localparam int unsigned CNT_W = $clog2(smap_pkg::QUOT_W + 1);

  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic                        done_r, done_nxt;
  logic [smap_pkg::QUOT_W-1:0] num_r, num_nxt;
  logic [smap_pkg::QUOT_W-1:0] rem_r, rem_nxt;
  logic [smap_pkg::SIZE_W-1:0] div_r, div_nxt;
  logic [smap_pkg::SIZE_W-1:0] trial;

  // rem stays below div (at most 32), so it always fits five bits
  assign trial = {rem_r, num_r[smap_pkg::QUOT_W-1]};

  always_comb begin
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    done_nxt = 1'b0;
    if (start) begin
      cnt_nxt = CNT_W'(smap_pkg::QUOT_W);
      num_nxt = num;
      rem_nxt = '0;
      div_nxt = div;
    end else if (cnt_r != '0) begin
      if (trial >= div_r) begin
        rem_nxt = smap_pkg::QUOT_W'(trial - div_r);
      end else begin
        rem_nxt = trial[smap_pkg::QUOT_W-1:0];
      end
      num_nxt  = {num_r[smap_pkg::QUOT_W-2:0], 1'b0};
      cnt_nxt  = cnt_r - CNT_W'(1);
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

@@ hw/rtl/serial_bank_mapper.sv @@
// ----------------------------------------------------------------------------
// serial_bank_mapper: serially loaded bank-switching mapper
// Takes register writes and PRG ROM, CHR and PRG RAM address translations.
// ----------------------------------------------------------------------------
// One word in at a time. A register write or a PRG RAM translation moves to
// the hold state at acceptance and then loads the output register; the
// next word is taken once the hold state is left. A PRG ROM or CHR
// translation first waits on the remainder unit, which reduces the bank
// number modulo the memory size one bit a cycle; the remainder is then
// collected into the pending result, which loads the output register.
// A result waiting on a full, stalled output register holds off the
// input; once it sits in the output register the next word is taken
// while it is still stalled.
// Size registers of zero act as one unit; values above 32 saturate at 32.
module serial_bank_mapper (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [15:0] in_addr,
  input  logic [7:0]  in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [18:0] out_offset,
  output logic        out_status,
  output logic [1:0]  out_mirroring,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_wdata
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0]  state_r, state_nxt;
  logic [5:0]  prg_banks_r, chr_units_r;
  logic        fixed_32k_r, ram_ctrl_r;

  logic        accept;
  logic        out_free;
  smap_pkg::smap_banks_t banks;

  logic [smap_pkg::SIZE_W-1:0] prg_div, chr_div, div_sel;
  logic [4:0]  prg_last;
  logic [4:0]  prg_hi, chr_hi, hi_sel;
  logic [1:0]  prg_mode;
  logic        rem_start, rem_done;
  logic [4:0]  rem;

  logic        is_chr_r;
  logic [13:0] low_r;
  logic [18:0] pend_offset_r, pend_offset_nxt;
  logic        pend_status_r, pend_status_nxt;
  logic        ram_off;

  logic        out_valid_r;
  logic [18:0] out_offset_r;
  logic        out_status_r;
  logic [1:0]  out_mirror_r;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_banks_r <= 6'd2;
      chr_units_r <= 6'd2;
      fixed_32k_r <= 1'b0;
      ram_ctrl_r  <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        smap_pkg::CFG_PRG_BANKS: prg_banks_r <= cfg_wdata;
        smap_pkg::CFG_CHR_UNITS: chr_units_r <= cfg_wdata;
        smap_pkg::CFG_FIXED_32K: fixed_32k_r <= cfg_wdata[0];
        smap_pkg::CFG_RAM_CTRL:  ram_ctrl_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  smap_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (accept && (in_action == smap_pkg::ACT_WRITE)),
    .wr_addr (in_addr),
    .wr_data (in_data),
    .banks   (banks)
  );

  // bank number (offset bits above the page) for each translation
  assign prg_div  = smap_pkg::clamp_units(prg_banks_r);
  assign chr_div  = smap_pkg::clamp_units(chr_units_r);
  assign prg_last = 5'(prg_div - smap_pkg::SIZE_W'(1));
  assign prg_mode = banks.control[3:2];

  always_comb begin
    if (!prg_mode[1]) begin
      prg_hi = {1'b0, banks.prg[3:1], in_addr[14]};
    end else if (fixed_32k_r) begin
      prg_hi = {4'd0, in_addr[14]};
    end else if (in_addr[14] == prg_mode[0]) begin
      // fixed window: first bank in mode 2, last bank in mode 3
      prg_hi = prg_mode[0] ? prg_last : 5'd0;
    end else begin
      prg_hi = {1'b0, banks.prg[3:0]};
    end
  end

  always_comb begin
    if (!banks.control[4]) begin
      chr_hi = {banks.chr_lo[4:1], in_addr[12]};
    end else begin
      chr_hi = in_addr[12] ? banks.chr_hi : banks.chr_lo;
    end
  end

  assign hi_sel    = (in_action == smap_pkg::ACT_CHR) ? chr_hi : prg_hi;
  assign div_sel   = (in_action == smap_pkg::ACT_CHR) ? chr_div : prg_div;
  assign rem_start = accept && ((in_action == smap_pkg::ACT_PRG_ROM) ||
                                (in_action == smap_pkg::ACT_CHR));
  assign ram_off   = ram_ctrl_r && banks.prg[4];

  smap_rem u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .start (rem_start),
    .num   (hi_sel),
    .div   (div_sel),
    .done  (rem_done),
    .rem   (rem)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      is_chr_r <= (in_action == smap_pkg::ACT_CHR);
      low_r    <= (in_action == smap_pkg::ACT_CHR) ? {2'b00, in_addr[11:0]}
                                                   : in_addr[13:0];
    end
  end

  always_comb begin
    state_nxt       = state_r;
    pend_offset_nxt = pend_offset_r;
    pend_status_nxt = pend_status_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          pend_offset_nxt = '0;
          pend_status_nxt = 1'b0;
          case (in_action)
            smap_pkg::ACT_PRG_ROM, smap_pkg::ACT_CHR: state_nxt = ST_CALC;
            smap_pkg::ACT_PRG_RAM: begin
              // (addr - 0x6000) mod 8 KB keeps the low thirteen bits
              if (ram_off) begin
                pend_status_nxt = 1'b1;
              end else begin
                pend_offset_nxt = {6'd0, in_addr[12:0]};
              end
              state_nxt = ST_HOLD;
            end
            default: state_nxt = ST_HOLD;
          endcase
        end
      end
      ST_CALC: begin
        if (rem_done) begin
          pend_offset_nxt = is_chr_r ? {2'b00, rem, low_r[11:0]} : {rem, low_r};
          state_nxt       = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == ST_HOLD) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    pend_offset_r <= pend_offset_nxt;
    pend_status_r <= pend_status_nxt;
    if ((state_r == ST_HOLD) && out_free) begin
      out_offset_r <= pend_offset_r;
      out_status_r <= pend_status_r;
      out_mirror_r <= banks.control[1:0];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_offset    = out_offset_r;
  assign out_status    = out_status_r;
  assign out_mirroring = out_mirror_r;

endmodule
